/* rtl/ps2kmd_pkg.sv */
// Package for the PS/2 keyboard and mouse decoder: payload types, constants and the scan table.
`default_nettype none

package ps2kmd_pkg;

   // Configuration register indexes (byte address is four times the index).
   localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
   localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
   localparam logic [1:0] REG_MOUSE_ENABLE  = 2'd2;

   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [12:0] SCREEN_WIDTH_RESET  = 13'd1024;
   localparam logic [12:0] SCREEN_HEIGHT_RESET = 13'd768;
   localparam logic [11:0] POS_X_RESET         = 12'd512;
   localparam logic [11:0] POS_Y_RESET         = 12'd384;

   // Set-1 scan codes with special handling.
   localparam logic [6:0] SCAN_LSHIFT = 7'h2A;
   localparam logic [6:0] SCAN_RSHIFT = 7'h36;
   localparam logic [6:0] SCAN_CAPS   = 7'h3A;

   localparam logic [6:0] ASCII_LOWER_A = 7'h61;
   localparam logic [6:0] ASCII_LOWER_Z = 7'h7A;
   localparam logic [6:0] ASCII_CASE    = 7'h20;

   typedef enum logic {
      EVENT_KEY   = 1'b0,
      EVENT_MOUSE = 1'b1
   } event_kind_type;

   typedef enum logic [1:0] {
      PHASE_HEADER = 2'd0,
      PHASE_DX     = 2'd1,
      PHASE_DY     = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       from_aux;
   } req_type;

   typedef struct packed {
      logic        event_kind;
      logic [6:0]  key_char;
      logic [11:0] cursor_x;
      logic [11:0] cursor_y;
      logic        left_down;
      logic        right_down;
      logic        left_pressed;
   } rsp_type;

   typedef struct packed {
      logic [12:0] screen_width;
      logic [12:0] screen_height;
      logic        mouse_enable;
   } cfg_type;

   typedef struct packed {
      logic       hit;
      logic [6:0] key_char;
   } kbd_result_type;

   typedef struct packed {
      logic        hit;
      logic [11:0] cursor_x;
      logic [11:0] cursor_y;
      logic        left_down;
      logic        right_down;
      logic        left_pressed;
   } mouse_result_type;

   // Set-1 make code to lowercase ASCII; zero marks a code with no character.
   function automatic logic [6:0] key_lookup(input logic [6:0] code);
      logic [6:0] c;
      unique case (code)
         7'd1:  c = 7'h1B;
         7'd2:  c = 7'h31;
         7'd3:  c = 7'h32;
         7'd4:  c = 7'h33;
         7'd5:  c = 7'h34;
         7'd6:  c = 7'h35;
         7'd7:  c = 7'h36;
         7'd8:  c = 7'h37;
         7'd9:  c = 7'h38;
         7'd10: c = 7'h39;
         7'd11: c = 7'h30;
         7'd12: c = 7'h2D;
         7'd13: c = 7'h3D;
         7'd14: c = 7'h08;
         7'd15: c = 7'h09;
         7'd16: c = 7'h71;
         7'd17: c = 7'h77;
         7'd18: c = 7'h65;
         7'd19: c = 7'h72;
         7'd20: c = 7'h74;
         7'd21: c = 7'h79;
         7'd22: c = 7'h75;
         7'd23: c = 7'h69;
         7'd24: c = 7'h6F;
         7'd25: c = 7'h70;
         7'd26: c = 7'h5B;
         7'd27: c = 7'h5D;
         7'd28: c = 7'h0A;
         7'd30: c = 7'h61;
         7'd31: c = 7'h73;
         7'd32: c = 7'h64;
         7'd33: c = 7'h66;
         7'd34: c = 7'h67;
         7'd35: c = 7'h68;
         7'd36: c = 7'h6A;
         7'd37: c = 7'h6B;
         7'd38: c = 7'h6C;
         7'd39: c = 7'h3B;
         7'd40: c = 7'h27;
         7'd41: c = 7'h60;
         7'd43: c = 7'h5C;
         7'd44: c = 7'h7A;
         7'd45: c = 7'h78;
         7'd46: c = 7'h63;
         7'd47: c = 7'h76;
         7'd48: c = 7'h62;
         7'd49: c = 7'h6E;
         7'd50: c = 7'h6D;
         7'd51: c = 7'h2C;
         7'd52: c = 7'h2E;
         7'd53: c = 7'h2F;
         7'd55: c = 7'h2A;
         7'd57: c = 7'h20;
         7'd74: c = 7'h2D;
         7'd78: c = 7'h2B;
         default: c = 7'h00;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

/* rtl/ps2kmd_csr.sv */
// Configuration registers of the PS/2 decoder behind an APB-style port.
`default_nettype none

module ps2kmd_csr
   import ps2kmd_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic      [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                           csr_pready,
   output cfg_type                        cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic       write_en;
   logic [1:0] reg_index;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = csr_paddr[CSR_ADDR_WIDTH-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_index)
            REG_SCREEN_WIDTH:  cfg_in.screen_width  = csr_pwdata[12:0];
            REG_SCREEN_HEIGHT: cfg_in.screen_height = csr_pwdata[12:0];
            REG_MOUSE_ENABLE:  cfg_in.mouse_enable  = csr_pwdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width  <= SCREEN_WIDTH_RESET;
         cfg_ff.screen_height <= SCREEN_HEIGHT_RESET;
         cfg_ff.mouse_enable  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_SCREEN_WIDTH:  csr_prdata = {19'd0, cfg_ff.screen_width};
         REG_SCREEN_HEIGHT: csr_prdata = {19'd0, cfg_ff.screen_height};
         REG_MOUSE_ENABLE:  csr_prdata = {31'd0, cfg_ff.mouse_enable};
         default:           csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* rtl/ps2kmd_kbd.sv */
// Keyboard scan code decoder: shift and caps lock tracking and ASCII mapping.
`default_nettype none

module ps2kmd_kbd
   import ps2kmd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       fire,
   input  wire logic [7:0] rx_byte,
   output kbd_result_type  result
);

   logic       shift_ff, shift_in;
   logic       caps_ff, caps_in;
   logic [6:0] code;
   logic [6:0] lower;
   logic       is_shift;
   logic       is_letter;

   assign code      = rx_byte[6:0];
   assign is_shift  = (code == SCAN_LSHIFT) || (code == SCAN_RSHIFT);
   assign lower     = key_lookup(code);
   assign is_letter = (lower >= ASCII_LOWER_A) && (lower <= ASCII_LOWER_Z);

   always_comb begin
      shift_in = shift_ff;
      caps_in  = caps_ff;
      if (fire) begin
         if (rx_byte[7]) begin
            if (is_shift) begin
               shift_in = 1'b0;
            end
         end else if (is_shift) begin
            shift_in = 1'b1;
         end else if (code == SCAN_CAPS) begin
            caps_in = !caps_ff;
         end
      end
   end

   // Shift and caps codes map to zero in the table, so they never give a character.
   always_comb begin
      result.hit      = fire && !rx_byte[7] && (lower != 7'd0);
      result.key_char = (is_letter && (shift_ff ^ caps_ff)) ? lower - ASCII_CASE : lower;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= 1'b0;
         caps_ff  <= 1'b0;
      end else begin
         shift_ff <= shift_in;
         caps_ff  <= caps_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/ps2kmd_mouse.sv */
// Mouse packet assembler and clamped cursor tracker.
`default_nettype none

module ps2kmd_mouse
   import ps2kmd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       fire,
   input  wire logic [7:0] rx_byte,
   input  cfg_type         cfg,
   output mouse_result_type result
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  header_ff, header_in;
   logic [7:0]  dx_ff, dx_in;
   logic [11:0] pos_x_ff, pos_x_in;
   logic [11:0] pos_y_ff, pos_y_in;
   logic        left_ff, left_in;
   logic        take;
   logic        complete;
   logic [13:0] sum_x;
   logic [13:0] sum_y;
   logic [11:0] clamp_x;
   logic [11:0] clamp_y;

   assign take = fire && cfg.mouse_enable;

   // Clamp a signed position into 0 .. size-1; size 0 acts as 1, above 4096 as 4096.
   function automatic logic [11:0] clamp_axis(input logic [13:0] v, input logic [12:0] size);
      logic [11:0] lim;
      if (size == 13'd0) begin
         lim = 12'd0;
      end else if (size[12]) begin
         lim = 12'hFFF;
      end else begin
         lim = size[11:0] - 12'd1;
      end
      if (v[13]) begin
         return 12'd0;
      end else if (v[12:0] > {1'b0, lim}) begin
         return lim;
      end else begin
         return v[11:0];
      end
   endfunction

   always_comb begin
      phase_in = phase_ff;
      if (take) begin
         unique case (phase_ff)
            PHASE_HEADER: phase_in = rx_byte[3] ? PHASE_DX : PHASE_HEADER;
            PHASE_DX:     phase_in = PHASE_DY;
            PHASE_DY:     phase_in = PHASE_HEADER;
            default:      phase_in = rx_byte[3] ? PHASE_DX : PHASE_HEADER;
         endcase
      end
   end

   assign complete = take && (phase_ff == PHASE_DY);

   always_comb begin
      sum_x = {2'b00, pos_x_ff} + {{6{header_ff[4]}}, dx_ff};
      sum_y = {2'b00, pos_y_ff} - {{6{header_ff[5]}}, rx_byte};
      clamp_x = clamp_axis(sum_x, cfg.screen_width);
      clamp_y = clamp_axis(sum_y, cfg.screen_height);

      header_in = header_ff;
      dx_in     = dx_ff;
      pos_x_in  = pos_x_ff;
      pos_y_in  = pos_y_ff;
      left_in   = left_ff;
      if (take && (phase_ff != PHASE_DX) && (phase_ff != PHASE_DY) && rx_byte[3]) begin
         header_in = rx_byte;
      end
      if (take && (phase_ff == PHASE_DX)) begin
         dx_in = rx_byte;
      end
      if (complete) begin
         pos_x_in = clamp_x;
         pos_y_in = clamp_y;
         left_in  = header_ff[0];
      end
   end

   always_comb begin
      result.hit          = complete;
      result.cursor_x     = clamp_x;
      result.cursor_y     = clamp_y;
      result.left_down    = header_ff[0];
      result.right_down   = header_ff[1];
      result.left_pressed = header_ff[0] && !left_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PHASE_HEADER;
         header_ff <= 8'd0;
         dx_ff     <= 8'd0;
         pos_x_ff  <= POS_X_RESET;
         pos_y_ff  <= POS_Y_RESET;
         left_ff   <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         header_ff <= header_in;
         dx_ff     <= dx_in;
         pos_x_ff  <= pos_x_in;
         pos_y_ff  <= pos_y_in;
         left_ff   <= left_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/ps2kmd_top_unused_guard.sv */
// Result staging register of the PS/2 decoder: merges keyboard and mouse events.
`default_nettype none

module ps2kmd_out
   import ps2kmd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       advance,
   input  kbd_result_type   kbd_result,
   input  mouse_result_type mouse_result,
   input  wire logic       rsp_ready,
   output logic            rsp_valid,
   output rsp_type         rsp_payload
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (advance) begin
         valid_in = kbd_result.hit || mouse_result.hit;
         if (mouse_result.hit) begin
            data_in.event_kind   = EVENT_MOUSE;
            data_in.key_char     = 7'd0;
            data_in.cursor_x     = mouse_result.cursor_x;
            data_in.cursor_y     = mouse_result.cursor_y;
            data_in.left_down    = mouse_result.left_down;
            data_in.right_down   = mouse_result.right_down;
            data_in.left_pressed = mouse_result.left_pressed;
         end else begin
            data_in              = '0;
            data_in.event_kind   = EVENT_KEY;
            data_in.key_char     = kbd_result.key_char;
         end
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

endmodule

`default_nettype wire

/* rtl/ps2_keyboard_mouse_decoder_core.sv */
// Top level of the PS/2 keyboard and mouse decoder.
//
// Usage: each beat on the req_ channel carries one byte read from a PS/2
// controller and a flag telling whether it came from the mouse port. Keyboard
// bytes are set-1 scan codes; mapped make codes produce one keyboard beat
// on the rsp_ channel, while shift, caps lock, releases and unmapped codes
// only update internal state. Mouse bytes are taken only while mouse_enable is
// set and are gathered into three-byte packets; the third byte of a packet
// produces one mouse beat with the clamped cursor and the button state.
// A byte accepted into the input register is decoded there and written to the
// result register, where rsp_valid rises. Throughput is one byte per cycle
// while the receiver does not stall, with the single add-and-clamp per axis as
// the longest path between the registers.
// While the receiver stalls, a pending result waits in the result register and
// the byte in the input register waits behind it, even one that yields no
// result, so req_ready falls until the result beat is taken.
// Reset clears shift and caps lock, restarts packet sync, puts the cursor at
// (512, 384) and loads the registers with 1024 x 768 and the mouse disabled.
// The configuration registers sit on the csr_ port at byte addresses 0, 4, 8.
`default_nettype none

module ps2_keyboard_mouse_decoder_core
   import ps2kmd_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  req_type                        req_payload,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output rsp_type                        rsp_payload,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic      [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                           csr_pready
);

   cfg_type          cfg;
   kbd_result_type   kbd_result;
   mouse_result_type mouse_result;

   // Input register holding the byte being decoded.
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff, in_data_in;
   logic    advance;

   // The decoded byte moves on whenever the result register is free or is
   // being emptied in this same cycle.
   assign advance   = in_valid_ff && (!rsp_valid || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_data_in  = req_payload;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
   end

   ps2kmd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Keyboard and mouse state only change on the cycle the byte is consumed.
   ps2kmd_kbd u_kbd (
      .clock   (clock),
      .reset   (reset),
      .fire    (advance && !in_data_ff.from_aux),
      .rx_byte (in_data_ff.rx_byte),
      .result  (kbd_result)
   );

   ps2kmd_mouse u_mouse (
      .clock   (clock),
      .reset   (reset),
      .fire    (advance && in_data_ff.from_aux),
      .rx_byte (in_data_ff.rx_byte),
      .cfg     (cfg),
      .result  (mouse_result)
   );

   ps2kmd_out u_out (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .kbd_result   (kbd_result),
      .mouse_result (mouse_result),
      .rsp_ready    (rsp_ready),
      .rsp_valid    (rsp_valid),
      .rsp_payload  (rsp_payload)
   );

endmodule

`default_nettype wire
